// ===== hw/rtl/pva_pkg.sv =====
package pva_pkg;

   // list geometry
   localparam int NUM_VOICES = 16;
   localparam int ID_W       = 4;
   localparam int NOTE_W     = 7;
   localparam int SLOT_W     = 8;

   // markers held by a free entry; neither equals a 7-bit note or zero
   localparam logic [SLOT_W-1:0] NOTE_NONE = 8'hFF;
   localparam logic [SLOT_W-1:0] VEL_FREE  = 8'hFF;

   // request opcodes
   localparam logic OP_NOTE = 1'b0;
   localparam logic OP_FREE = 1'b1;

   // cell update codes
   localparam logic [1:0] CELL_HOLD      = 2'd0;
   localparam logic [1:0] CELL_FROM_PREV = 2'd1;
   localparam logic [1:0] CELL_FROM_NEXT = 2'd2;
   localparam logic [1:0] CELL_SILENCE   = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [SLOT_W-1:0] note;
      logic [SLOT_W-1:0] vel;
   } entry_type;

   typedef struct packed {
      logic       sample;
      logic [1:0] op;
   } cell_ctrl_type;

   typedef struct packed {
      logic id_hit;
      logic note_hit;
   } cell_hit_type;

endpackage

// ===== hw/rtl/pva_cell.sv =====
module pva_cell import pva_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [ID_W-1:0]     cell_index,
   input  cell_ctrl_type       ctrl,
   input  logic [NOTE_W-1:0]   cmd_note,
   input  logic [ID_W-1:0]     cmd_free_voice,
   input  entry_type           prev_entry,
   input  entry_type           next_entry,
   output entry_type           entry,
   output cell_hit_type        hit
);

   entry_type    entry_ff, entry_in;
   cell_hit_type hit_ff, hit_in;

   // compare the incoming beat against this entry
   always_comb begin
      hit_in = hit_ff;
      if (ctrl.sample) begin
         hit_in.id_hit   = (entry_ff.id == cmd_free_voice);
         hit_in.note_hit = (entry_ff.note == {1'b0, cmd_note}) && (entry_ff.vel != '0);
      end
   end

   // entry update from the neighbors
   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         CELL_HOLD:      entry_in = entry_ff;
         CELL_FROM_PREV: entry_in = prev_entry;
         CELL_FROM_NEXT: entry_in = next_entry;
         CELL_SILENCE:   entry_in.vel = '0;
         default:        entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.id   <= cell_index;
         entry_ff.note <= NOTE_NONE;
         entry_ff.vel  <= VEL_FREE;
         hit_ff        <= '0;
      end else begin
         entry_ff <= entry_in;
         hit_ff   <= hit_in;
      end
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

// ===== hw/rtl/polyphonic_voice_allocator_top.sv =====
// Oldest-first voice allocator over a row of 16 list cells. A beat is taken
// when start is high and busy is low. For each beat every cell first
// registers its compare against the beat, then the whole row updates at once
// (busy is high in that cycle), so no new beat is taken until the update is
// done. A note-on or a matched note-off puts one result on the rsp_ ports for
// a single cycle, marked by rsp_strobe, in the cycle after the update; the
// receiver cannot hold it off and must take it in that cycle.
// Free reports and unmatched note-offs give no result.
module polyphonic_voice_allocator_top import pva_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_opcode,
   input  logic [6:0]        req_note,
   input  logic [6:0]        req_velocity,
   input  logic [3:0]        req_free_voice,
   output logic              rsp_strobe,
   output logic [3:0]        rsp_voice,
   output logic [6:0]        rsp_out_note,
   output logic [6:0]        rsp_out_velocity,
   output logic              rsp_note_sent
);

   logic accept;
   logic phase_ff, phase_in;
   logic              cmd_op_ff;
   logic [NOTE_W-1:0] cmd_note_ff;
   logic [6:0]        cmd_vel_ff;
   logic [ID_W-1:0]   cmd_fv_ff;

   entry_type       cell_entry [NUM_VOICES];
   cell_hit_type    cell_hit   [NUM_VOICES];
   cell_ctrl_type   cell_ctrl  [NUM_VOICES];
   logic [NUM_VOICES-1:0] id_hit_vec, note_hit_vec, first_hit_vec;

   entry_type fresh_entry, back_entry;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [ID_W-1:0]   rsp_voice_ff, rsp_voice_in;
   logic [6:0]        rsp_note_ff, rsp_note_in;
   logic [6:0]        rsp_vel_ff, rsp_vel_in;
   logic              rsp_sent_ff, rsp_sent_in;
   logic [ID_W-1:0]   off_voice;

   assign accept   = start && !phase_ff;
   assign phase_in = accept;
   assign busy     = phase_ff;

   // control and command registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_op_ff   <= req_opcode;
         cmd_note_ff <= req_note;
         cmd_vel_ff  <= req_velocity;
         cmd_fv_ff   <= req_free_voice;
      end
   end

   // entries fed in at both ends of the row
   assign fresh_entry = '{id: cmd_fv_ff, note: NOTE_NONE, vel: VEL_FREE};
   assign back_entry  = '{id: cell_entry[0].id, note: {1'b0, cmd_note_ff},
                          vel: {1'b0, cmd_vel_ff}};

   // gather the registered hit flags
   always_comb begin
      for (int i = 0; i < NUM_VOICES; i++) begin
         id_hit_vec[i]   = cell_hit[i].id_hit;
         note_hit_vec[i] = cell_hit[i].note_hit;
      end
   end

   // per-cell update codes for the update cycle
   always_comb begin
      for (int i = 0; i < NUM_VOICES; i++) begin
         first_hit_vec[i]   = note_hit_vec[i] &&
                              !(|(note_hit_vec & ~({NUM_VOICES{1'b1}} << i)));
         cell_ctrl[i].sample = accept;
         cell_ctrl[i].op     = CELL_HOLD;
         if (phase_ff) begin
            if (cmd_op_ff == OP_FREE) begin
               // entries in front of the freed voice slide back by one
               if (|(id_hit_vec >> i)) begin
                  cell_ctrl[i].op = CELL_FROM_PREV;
               end
            end else if (cmd_vel_ff == '0) begin
               if (first_hit_vec[i]) begin
                  cell_ctrl[i].op = CELL_SILENCE;
               end
            end else begin
               cell_ctrl[i].op = CELL_FROM_NEXT;
            end
         end
      end
   end

   // row of list cells
   for (genvar g = 0; g < NUM_VOICES; g++) begin : g_cell
      entry_type prev_e, next_e;
      if (g == 0) begin : g_head
         assign prev_e = fresh_entry;
      end else begin : g_mid
         assign prev_e = cell_entry[g-1];
      end
      if (g == NUM_VOICES - 1) begin : g_tail
         assign next_e = back_entry;
      end else begin : g_body
         assign next_e = cell_entry[g+1];
      end
      pva_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .cell_index     (ID_W'(g)),
         .ctrl           (cell_ctrl[g]),
         .cmd_note       (req_note),
         .cmd_free_voice (req_free_voice),
         .prev_entry     (prev_e),
         .next_entry     (next_e),
         .entry          (cell_entry[g]),
         .hit            (cell_hit[g])
      );
   end

   // voice of the first matching note-off entry
   always_comb begin
      off_voice = '0;
      for (int i = 0; i < NUM_VOICES; i++) begin
         off_voice = off_voice | (cell_entry[i].id & {ID_W{first_hit_vec[i]}});
      end
   end

   // result beat
   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_voice_in  = off_voice;
      rsp_note_in   = '0;
      rsp_vel_in    = '0;
      rsp_sent_in   = 1'b0;
      if (phase_ff && cmd_op_ff == OP_NOTE) begin
         if (cmd_vel_ff == '0) begin
            rsp_strobe_in = |note_hit_vec;
         end else begin
            rsp_strobe_in = 1'b1;
            rsp_voice_in  = cell_entry[0].id;
            rsp_note_in   = cmd_note_ff;
            rsp_vel_in    = cmd_vel_ff;
            rsp_sent_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_voice_ff <= rsp_voice_in;
      rsp_note_ff  <= rsp_note_in;
      rsp_vel_ff   <= rsp_vel_in;
      rsp_sent_ff  <= rsp_sent_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_voice        = rsp_voice_ff;
   assign rsp_out_note     = rsp_note_ff;
   assign rsp_out_velocity = rsp_vel_ff;
   assign rsp_note_sent    = rsp_sent_ff;

   // checks
   a_update_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy) else $error("update cycle lasted more than one cycle");

   a_strobe_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("result without an update cycle");

   a_ids_unique: assert property (@(posedge clock) disable iff (reset)
      busy |-> $onehot0(id_hit_vec)) else $error("voice id held by two cells");

   a_note_on_velocity: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_note_sent) |-> (rsp_out_velocity != '0))
      else $error("note-on result with zero velocity");

endmodule

// ===== test/tb_polyphonic_voice_allocator_top.sv =====
module tb_polyphonic_voice_allocator_top;
   import pva_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      logic [3:0] voice;
      logic [6:0] note;
      logic [6:0] vel;
      logic       sent;
   } voice_msg_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic       req_opcode = OP_NOTE;
   logic [6:0] req_note = '0;
   logic [6:0] req_velocity = '0;
   logic [3:0] req_free_voice = '0;
   logic       rsp_strobe;
   logic [3:0] rsp_voice;
   logic [6:0] rsp_out_note;
   logic [6:0] rsp_out_velocity;
   logic       rsp_note_sent;

   // predicted voice list, front at index 0
   logic [ID_W-1:0]   order_voice [NUM_VOICES];
   logic [SLOT_W-1:0] order_note  [NUM_VOICES];
   logic [SLOT_W-1:0] order_vel   [NUM_VOICES];

   voice_msg_type pending_msgs[$];
   int            error_count = 0;
   int            cycle_count = 0;
   bit            gaps_on = 1'b1;

   polyphonic_voice_allocator_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_note         (req_note),
      .req_velocity     (req_velocity),
      .req_free_voice   (req_free_voice),
      .rsp_strobe       (rsp_strobe),
      .rsp_voice        (rsp_voice),
      .rsp_out_note     (rsp_out_note),
      .rsp_out_velocity (rsp_out_velocity),
      .rsp_note_sent    (rsp_note_sent)
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic void clear_voice_list();
      for (int i = 0; i < NUM_VOICES; i++) begin
         order_voice[i] = ID_W'(i);
         order_note[i]  = NOTE_NONE;
         order_vel[i]   = VEL_FREE;
      end
   endfunction

   // apply one beat to the predicted list; returns 1 when a message goes out
   function automatic bit allocate_voice(input logic op, input logic [6:0] note,
                                         input logic [6:0] vel, input logic [3:0] fv,
                                         output voice_msg_type msg);
      logic [ID_W-1:0] id;
      int              pos;
      msg = '{voice: '0, note: '0, vel: '0, sent: 1'b0};
      if (op == OP_FREE) begin
         pos = -1;
         for (int i = 0; i < NUM_VOICES; i++)
            if (pos < 0 && order_voice[i] == fv) pos = i;
         if (pos >= 0) begin
            id = order_voice[pos];
            for (int i = pos; i > 0; i--) begin
               order_voice[i] = order_voice[i-1];
               order_note[i]  = order_note[i-1];
               order_vel[i]   = order_vel[i-1];
            end
            order_voice[0] = id;
            order_note[0]  = NOTE_NONE;
            order_vel[0]   = VEL_FREE;
         end
         return 1'b0;
      end
      if (vel == 0) begin
         for (int i = 0; i < NUM_VOICES; i++) begin
            if (order_note[i] == {1'b0, note} && order_vel[i] != 0) begin
               order_vel[i] = '0;
               msg.voice = order_voice[i];
               return 1'b1;
            end
         end
         return 1'b0;
      end
      // note-on takes the oldest voice at the front
      id = order_voice[0];
      for (int i = 0; i < NUM_VOICES - 1; i++) begin
         order_voice[i] = order_voice[i+1];
         order_note[i]  = order_note[i+1];
         order_vel[i]   = order_vel[i+1];
      end
      order_voice[NUM_VOICES-1] = id;
      order_note[NUM_VOICES-1]  = {1'b0, note};
      order_vel[NUM_VOICES-1]   = {1'b0, vel};
      msg.voice = id;
      msg.note  = note;
      msg.vel   = vel;
      msg.sent  = 1'b1;
      return 1'b1;
   endfunction

   // result checker
   always @(posedge clock) begin
      voice_msg_type want;
      if (!reset && rsp_strobe) begin
         if (pending_msgs.size() == 0) begin
            report_mismatch("unexpected result, voice", int'(rsp_voice), -1);
         end else begin
            want = pending_msgs[0];
            pending_msgs.delete(0);
            if (rsp_voice !== want.voice)
               report_mismatch("voice", int'(rsp_voice), int'(want.voice));
            if (rsp_out_note !== want.note)
               report_mismatch("out_note", int'(rsp_out_note), int'(want.note));
            if (rsp_out_velocity !== want.vel)
               report_mismatch("out_velocity", int'(rsp_out_velocity), int'(want.vel));
            if (rsp_note_sent !== want.sent)
               report_mismatch("note_sent", int'(rsp_note_sent), int'(want.sent));
         end
      end
   end

   // one beat to the block; start stays high on return unless a random gap follows, has_msg is 1 if a result is due
   task automatic send_beat(input logic op, input logic [6:0] note, input logic [6:0] vel,
                            input logic [3:0] fv, output bit has_msg);
      voice_msg_type msg;
      start          <= 1'b1;
      req_opcode     <= op;
      req_note       <= note;
      req_velocity   <= vel;
      req_free_voice <= fv;
      do @(posedge clock); while (busy);
      has_msg = allocate_voice(op, note, vel, fv, msg);
      if (has_msg) pending_msgs.insert(pending_msgs.size(), msg);
      // random gap after the beat
      if (gaps_on && $urandom_range(0, 99) < 21) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic note_beat(input logic [6:0] note, input logic [6:0] vel);
      bit has_msg;
      send_beat(OP_NOTE, note, vel, 4'($urandom), has_msg);
   endtask

   task automatic free_beat(input logic [3:0] fv);
      bit has_msg;
      send_beat(OP_FREE, 7'($urandom), 7'($urandom), fv, has_msg);
   endtask

   // stop sending until every expected result is back
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_msgs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_unmatched_release();
      note_beat(7'd0, 7'd0);
      note_beat(7'd127, 7'd0);
   endtask

   task automatic test_note_on_off();
      note_beat(7'd0, 7'd1);
      note_beat(7'd127, 7'd127);
      note_beat(7'd127, 7'd0);
      // already released, so no match
      note_beat(7'd127, 7'd0);
   endtask

   task automatic test_free_reports();
      // voice 2 is at the front here
      free_beat(4'd2);
      free_beat(4'd0);
      // voice 0 lost its note, so nothing matches
      note_beat(7'd0, 7'd0);
      free_beat(4'd15);
   endtask

   task automatic test_duplicate_notes();
      note_beat(7'd5, 7'd64);
      note_beat(7'd5, 7'd85);
      note_beat(7'd5, 7'd0);
   endtask

   task automatic test_voice_stealing();
      // a full turn of the list takes voices that still hold notes
      for (int i = 0; i < NUM_VOICES; i++)
         note_beat(7'(40 + i), 7'(10 + 7 * i));
   endtask

   task automatic test_random_traffic(input int beats, input bit with_gaps);
      int         counted;
      int         pick;
      int         slot;
      bit         has_msg;
      logic [6:0] note;
      gaps_on = with_gaps;
      counted = 0;
      while (counted < beats) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            note = ($urandom_range(0, 1) != 0) ? 7'($urandom_range(60, 67))
                                               : 7'($urandom_range(0, 127));
            send_beat(OP_NOTE, note, 7'($urandom_range(1, 127)), 4'($urandom), has_msg);
         end else if (pick < 75) begin
            // release mostly a note that some voice holds
            slot = $urandom_range(0, NUM_VOICES - 1);
            if ($urandom_range(0, 99) < 70 && order_note[slot] != NOTE_NONE)
               note = order_note[slot][6:0];
            else
               note = 7'($urandom_range(60, 67));
            send_beat(OP_NOTE, note, 7'd0, 4'($urandom), has_msg);
         end else if (pick < 90) begin
            send_beat(OP_FREE, 7'($urandom), 7'($urandom), 4'($urandom), has_msg);
         end else begin
            send_beat(1'($urandom), 7'($urandom), 7'($urandom), 4'($urandom), has_msg);
         end
         counted++;
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      clear_voice_list();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_unmatched_release();
      test_note_on_off();
      test_free_reports();
      test_duplicate_notes();
      test_voice_stealing();
      wait_drained();

      test_random_traffic(550, 1'b1);
      wait_drained();
      test_random_traffic(350, 1'b0);
      test_random_traffic(500, 1'b1);

      // end of stimulus
      start <= 1'b0;
      while (pending_msgs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_msgs.size() != 0) report_mismatch("results left over", pending_msgs.size(), 0);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
